// ----- hw/rtl/tfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tfp_pkg
// shared types and constants for the tlv frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMMAND    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RESPONSE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINT_COMMAND  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_MARK      = 8'd3;

    // configuration reset values
    localparam logic [BYTE_W-1:0] RST_MAX_COMMAND    = 8'd16;
    localparam logic [BYTE_W-1:0] RST_RESET_RESPONSE = 8'd0;
    localparam logic [BYTE_W-1:0] RST_PRINT_COMMAND  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_TERM_MARK      = 8'd255;

    localparam logic [BYTE_W-1:0] NUL_BYTE = 8'd0;

    typedef enum logic [2:0] {
        PH_COMMAND = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_COUNTED = 3'd2,
        PH_TERM    = 3'd3,
        PH_TEXT    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_EMPTY   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] max_command;
        logic [BYTE_W-1:0] reset_response;
        logic [BYTE_W-1:0] print_command;
        logic [BYTE_W-1:0] term_mark;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/tfp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tfp_cfg_regs
// configuration register file, written by index
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [tfp_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [tfp_pkg::BYTE_W-1:0]     i_wr_data,
    output tfp_pkg::t_cfg                       o_cfg
);

    tfp_pkg::t_cfg r_cfg;
    tfp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                tfp_pkg::CFG_MAX_COMMAND:    n_cfg.max_command    = i_wr_data;
                tfp_pkg::CFG_RESET_RESPONSE: n_cfg.reset_response = i_wr_data;
                tfp_pkg::CFG_PRINT_COMMAND:  n_cfg.print_command  = i_wr_data;
                tfp_pkg::CFG_TERM_MARK:      n_cfg.term_mark      = i_wr_data;
                default: ; // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_command    <= tfp_pkg::RST_MAX_COMMAND;
            r_cfg.reset_response <= tfp_pkg::RST_RESET_RESPONSE;
            r_cfg.print_command  <= tfp_pkg::RST_PRINT_COMMAND;
            r_cfg.term_mark      <= tfp_pkg::RST_TERM_MARK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/tfp_parser.sv -----
// ----------------------------------------------------------------------------
// tfp_parser
// frame state machine with the result register
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tfp_pkg::t_cfg               i_cfg,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [tfp_pkg::BYTE_W-1:0]  i_byte,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output tfp_pkg::t_result                 o_result
);

    tfp_pkg::t_phase              r_phase,   n_phase;
    logic [tfp_pkg::BYTE_W-1:0]   r_command, n_command;
    logic [tfp_pkg::BYTE_W-1:0]   r_length,  n_length;
    logic [tfp_pkg::BYTE_W-1:0]   r_count,   n_count;
    logic                         r_out_valid, n_out_valid;
    tfp_pkg::t_result             r_result,  n_result;

    logic                         advance;
    logic                         emit;
    logic [tfp_pkg::BYTE_W-1:0]   count_inc;
    logic                         is_nul;

    // the result slot frees up when empty or taken this cycle
    assign o_ready   = !r_out_valid || i_ready;
    assign advance   = i_valid && o_ready;
    assign count_inc = r_count + 8'd1;
    assign is_nul    = (i_byte == tfp_pkg::NUL_BYTE);

    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_length  = r_length;
        n_count   = r_count;
        emit      = 1'b0;
        n_result.kind    = tfp_pkg::KIND_PAYLOAD;
        n_result.command = r_command;
        n_result.length  = r_length;
        n_result.data    = i_byte;
        n_result.last    = 1'b0;

        unique case (r_phase)
            tfp_pkg::PH_LENGTH: begin
                n_length = i_byte;
                n_count  = '0;
                if (r_command == i_cfg.print_command) begin
                    n_phase = tfp_pkg::PH_TEXT;
                end else if (i_byte == i_cfg.term_mark) begin
                    n_phase = tfp_pkg::PH_TERM;
                end else if (!is_nul) begin
                    n_phase = tfp_pkg::PH_COUNTED;
                end else begin
                    n_phase          = tfp_pkg::PH_COMMAND;
                    emit             = 1'b1;
                    n_result.kind    = tfp_pkg::KIND_EMPTY;
                    n_result.length  = i_byte;
                    n_result.data    = tfp_pkg::NUL_BYTE;
                    n_result.last    = 1'b1;
                end
            end
            tfp_pkg::PH_COUNTED: begin
                n_count       = count_inc;
                emit          = 1'b1;
                n_result.last = (count_inc >= r_length);
                if (count_inc >= r_length) begin
                    n_phase = tfp_pkg::PH_COMMAND;
                end
            end
            tfp_pkg::PH_TERM: begin
                emit          = 1'b1;
                n_result.last = is_nul;
                if (is_nul) begin
                    n_phase = tfp_pkg::PH_COMMAND;
                end
            end
            tfp_pkg::PH_TEXT: begin
                emit          = 1'b1;
                n_result.kind = tfp_pkg::KIND_TEXT;
                n_result.last = is_nul;
                if (is_nul) begin
                    n_phase = tfp_pkg::PH_COMMAND;
                end
            end
            default: begin
                // waiting for a command byte; odd codes land here too
                n_phase = tfp_pkg::PH_COMMAND;
                if (!(i_byte > i_cfg.max_command) && (i_byte != i_cfg.reset_response)) begin
                    n_command = i_byte;
                    n_phase   = tfp_pkg::PH_LENGTH;
                end
            end
        endcase

        if (advance) begin
            n_out_valid = emit;
        end else begin
            n_out_valid = r_out_valid && !i_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tfp_pkg::PH_COMMAND;
            r_command   <= '0;
            r_length    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_phase   <= n_phase;
                r_command <= n_command;
                r_length  <= n_length;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hw/rtl/tlv_frame_parser.sv -----
// ----------------------------------------------------------------------------
// tlv_frame_parser
// type-length-value deframer: command byte, length byte, then body bytes
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  --------------------------------
//  s_axis    in         i_s_tvalid / o_s_tready   tdata[7:0] rx byte
//  m_axis    out        o_m_tvalid / i_m_tready   tdata cmd/len/data, tuser kind,
//                                                 tlast end of frame
//  cfg       in         i_cfg_valid / o_cfg_ready index + 8-bit write data
//
//  one byte per cycle sustained while the output is not stalled; a byte passes
//  an input register, then the frame state machine and the result register
//  before a body byte is offered on the output
//  reset is synchronous and active low; it returns the parser to waiting for
//  a command byte and loads the register defaults
//  a stalled output holds the result and backpressures through the input
//  register; command bytes and nonzero length bytes produce no result
//
`default_nettype none

module tlv_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // received byte stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte

    // parsed result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [7:0] frame_command, [15:8] frame_length,
                                          // [23:16] data_byte
    output logic [1:0]       o_m_tuser,   // [1:0] item_kind
    output logic             o_m_tlast,   // frame_last

    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    tfp_pkg::t_cfg    cfg;
    tfp_pkg::t_result result;

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       core_ready;

    // writes are always taken; keeping them to times when the stream is idle is up to the user, unchecked by the block
    assign o_cfg_ready = 1'b1;

    tfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register refills whenever it is empty or drains this cycle
    assign o_s_tready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    tfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (r_in_valid),
        .o_ready  (core_ready),
        .i_byte   (r_in_byte),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    // pack the result: command lowest, then length, then data byte
    assign o_m_tdata = {result.data, result.length, result.command};
    assign o_m_tuser = result.kind;
    assign o_m_tlast = result.last;

endmodule

`default_nettype wire
